FILE: sv/dupf_pkg.sv
// ----------------------------------------------------------------------------
// dupf_pkg
// Shared constants, types and state codes of the bounded duplicate filter.
// ----------------------------------------------------------------------------
package dupf_pkg;

  // number of nonces the filter can hold
  localparam int unsigned CAPACITY_ENTRIES = 256;

  localparam int unsigned NONCE_W = 32;
  localparam int unsigned OCC_W   = 9;
  // held count must reach CAPACITY_ENTRIES itself
  localparam int unsigned CNT_W   = $clog2(CAPACITY_ENTRIES + 1);
  // count widened so that the 9-bit occupancy field can always be sliced off
  localparam int unsigned EXT_W   = (CNT_W > OCC_W) ? CNT_W : OCC_W;
  // result transaction: is_new, evicted, occupancy padded to whole bytes
  localparam int unsigned RES_W   = 2 + OCC_W;
  localparam int unsigned OUT_W   = ((RES_W + 7) / 8) * 8;

  typedef logic [NONCE_W-1:0] nonce_t;
  typedef logic [CNT_W-1:0]   count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } state_e;

  // controls from the sequencer into the cell row
  typedef struct packed {
    logic inject;  // start a probe token at the head cell
    logic shift;   // move every entry one cell down, query enters at head
  } chain_ctl_t;

  // status from the tail of the cell row
  typedef struct packed {
    logic done;    // probe token has left the last cell
    logic hit;     // some held entry matched the query
  } chain_sts_t;

endpackage

FILE: sv/dupf_cell.sv
// ----------------------------------------------------------------------------
// dupf_cell
// One storage cell: holds one nonce, compares it with the query as the probe
// token passes, and hands its entry to the next cell on an insert.
// ----------------------------------------------------------------------------
module dupf_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_i,
  input  logic              hit_i,
  input  dupf_pkg::nonce_t  key_i,
  input  logic              shift_i,
  input  logic              valid_i,
  input  dupf_pkg::nonce_t  query_i,
  output logic              tok_o,
  output logic              hit_o,
  output dupf_pkg::nonce_t  key_o
);
  import dupf_pkg::*;

  logic   tok_q, tok_d;
  logic   hit_q, hit_d;
  nonce_t key_q, key_d;

  // probe token and running match flag move on one cell per cycle
  always_comb begin
    tok_d = tok_i;
    hit_d = tok_i & (hit_i | (valid_i & (key_q == query_i)));
    key_d = shift_i ? key_i : key_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      hit_q <= hit_d;
    end
  end

  // stored entry, meaningful only while counted as held
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign tok_o = tok_q;
  assign hit_o = hit_q;
  assign key_o = key_q;

endmodule

FILE: sv/dupf_chain.sv
// ----------------------------------------------------------------------------
// dupf_chain
// Row of storage cells, youngest entry at the head, oldest in the last held cell.
// ----------------------------------------------------------------------------
module dupf_chain (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dupf_pkg::chain_ctl_t  ctl_i,
  input  dupf_pkg::nonce_t      query_i,
  input  dupf_pkg::count_t      count_i,
  output dupf_pkg::chain_sts_t  sts_o
);
  import dupf_pkg::*;

  logic   tok [CAPACITY_ENTRIES];
  logic   hit [CAPACITY_ENTRIES];
  nonce_t key [CAPACITY_ENTRIES];

  for (genvar i = 0; i < CAPACITY_ENTRIES; i++) begin : g_cell
    logic   tok_in;
    logic   hit_in;
    nonce_t key_in;
    logic   held;

    // head cell takes the new token and the query, others their neighbour
    if (i == 0) begin : g_head
      assign tok_in = ctl_i.inject;
      assign hit_in = 1'b0;
      assign key_in = query_i;
    end else begin : g_body
      assign tok_in = tok[i-1];
      assign hit_in = hit[i-1];
      assign key_in = key[i-1];
    end

    // cell holds a live entry when its place is below the held count
    assign held = (count_i > CNT_W'(i));

    dupf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok_in),
      .hit_i   (hit_in),
      .key_i   (key_in),
      .shift_i (ctl_i.shift),
      .valid_i (held),
      .query_i (query_i),
      .tok_o   (tok[i]),
      .hit_o   (hit[i]),
      .key_o   (key[i])
    );
  end

  assign sts_o.done = tok[CAPACITY_ENTRIES-1];
  assign sts_o.hit  = hit[CAPACITY_ENTRIES-1];

endmodule

FILE: sv/duplicate_filter_fifo_evict.sv
// ----------------------------------------------------------------------------
// duplicate_filter_fifo_evict
// Bounded duplicate filter: reports whether a 32-bit nonce is new, keeps up to
// CAPACITY_ENTRIES distinct nonces and drops the oldest when full.
//
//   channel   dir  payload                                   handshake
//   s_axis    in   tdata[31:0] nonce                         tvalid/tready
//   m_axis    out  tdata[0] is_new, [1] evicted,             tvalid/tready
//                  [10:2] occupancy, [15:11] zero
//
// From acceptance, a probe token walks the row of cells one cell per cycle and
// the match is latched; then the commit step writes the result register and
// inserts the nonce. The next nonce is accepted in the cycle after the commit,
// even while the previous result still waits in the output register, so no
// nonce is taken before the previous one has been committed.
// A stalled output holds the block in the commit step until the register frees.
// Reset clears the held count; stored nonces need no clearing.
// ----------------------------------------------------------------------------
module duplicate_filter_fifo_evict (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [dupf_pkg::NONCE_W-1:0] s_axis_tdata,  // [31:0] nonce
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [dupf_pkg::OUT_W-1:0] m_axis_tdata    // [0] is_new, [1] evicted,
                                                     // [10:2] occupancy
);
  import dupf_pkg::*;

  state_e     state_q, state_d;
  nonce_t     query_q, query_d;
  logic       found_q, found_d;
  count_t     count_q, count_d;
  logic       out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_data_q, out_data_d;

  chain_ctl_t ctl;
  chain_sts_t sts;
  logic       accept;
  logic       out_free;
  logic       full;
  logic       evict;
  count_t     count_next;
  logic [EXT_W-1:0] count_ext;
  nonce_t     probe_key;

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign out_free = ~out_valid_q | m_axis_tready;
  assign full     = (count_q == CNT_W'(CAPACITY_ENTRIES));
  assign evict    = ~found_q & full;

  // head cell compares the incoming nonce in the cycle the token is injected
  assign probe_key = (state_q == ST_IDLE) ? s_axis_tdata : query_q;

  // held count after this transaction
  always_comb begin
    count_next = count_q;
    if (!found_q && !full) begin
      count_next = count_q + CNT_W'(1);
    end
  end
  assign count_ext = EXT_W'(count_next);

  // sequencer: accept, walk the probe through the cells, commit
  always_comb begin
    state_d     = state_q;
    query_d     = query_q;
    found_d     = found_q;
    count_d     = count_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    ctl.inject  = 1'b0;
    ctl.shift   = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          query_d    = s_axis_tdata;
          ctl.inject = 1'b1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.done) begin
          found_d = sts.hit;
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_W'({count_ext[OCC_W-1:0], evict, ~found_q});
          ctl.shift   = ~found_q;
          count_d     = count_next;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    query_q    <= query_d;
    found_q    <= found_d;
    out_data_q <= out_data_d;
  end

  dupf_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .query_i (probe_key),
    .count_i (count_q),
    .sts_o   (sts)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for duplicate_filter_fifo_evict. Nonces go in on the
// slave stream: a short directed set first, then random traffic. Most random
// nonces are fresh or repeat held, oldest or recently dropped entries, so the
// store fills, wraps and evicts. A scoreboard tracks the held nonces in
// arrival order and checks each verdict on the master stream. Both streams
// idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import dupf_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned CYCLE_LIMIT  = 2_500_000;
  // probe walk through every cell plus the commit cycle, with some margin
  localparam int unsigned DRAIN_CYCLES = CAPACITY_ENTRIES + 8;

  // one expected verdict
  typedef struct packed {
    logic             is_new;
    logic             evicted;
    logic [OCC_W-1:0] occupancy;
  } verdict_t;

  // receiver back-pressure patterns
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_CHOPPY,
    RX_ALTERNATE,
    RX_LONG
  } rx_mode_e;

  // --------------------------------------------------------------------------
  // Scoreboard: held nonces in arrival order and the verdicts still owed
  // --------------------------------------------------------------------------
  class nonce_history;
    nonce_t      ring [CAPACITY_ENTRIES];
    int unsigned head;
    int unsigned held;
    verdict_t    verdict_q[$];
    nonce_t      dropped_q[$];
    int unsigned faults;
    int unsigned fresh_cnt;
    int unsigned repeat_cnt;
    int unsigned drop_cnt;
    int unsigned checked_cnt;

    function new();
      head        = 0;
      held        = 0;
      faults      = 0;
      fresh_cnt   = 0;
      repeat_cnt  = 0;
      drop_cnt    = 0;
      checked_cnt = 0;
    endfunction

    // accepted nonce: compare against held entries, update the ring
    function void note_nonce(nonce_t n);
      verdict_t    v;
      bit          hit;
      int unsigned k;
      hit = 1'b0;
      for (k = 0; k < held; k++) begin
        if (ring[(head + k) % CAPACITY_ENTRIES] == n) hit = 1'b1;
      end
      v = '0;
      if (hit) begin
        repeat_cnt++;
      end else begin
        v.is_new = 1'b1;
        fresh_cnt++;
        if (held < CAPACITY_ENTRIES) begin
          ring[(head + held) % CAPACITY_ENTRIES] = n;
          held++;
        end else begin
          // full: oldest slot is overwritten, age order moves on by one
          dropped_q.push_back(ring[head]);
          if (dropped_q.size() > 16) void'(dropped_q.pop_front());
          ring[head] = n;
          head       = (head + 1) % CAPACITY_ENTRIES;
          v.evicted  = 1'b1;
          drop_cnt++;
        end
      end
      v.occupancy = OCC_W'(held);
      verdict_q.push_back(v);
    endfunction

    // result transaction against the oldest outstanding verdict
    function void check_verdict(logic [OUT_W-1:0] data);
      verdict_t want;
      verdict_t got;
      got.is_new    = data[0];
      got.evicted   = data[1];
      got.occupancy = data[OCC_W+1:2];
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, no nonce outstanding, tdata %h", $time, data);
        faults++;
        return;
      end
      want = verdict_q.pop_front();
      checked_cnt++;
      if (got.is_new !== want.is_new) begin
        $display("%0t: is_new mismatch, expected %0d actual %0d",
                 $time, want.is_new, got.is_new);
        faults++;
      end
      if (got.evicted !== want.evicted) begin
        $display("%0t: evicted mismatch, expected %0d actual %0d",
                 $time, want.evicted, got.evicted);
        faults++;
      end
      if (got.occupancy !== want.occupancy) begin
        $display("%0t: occupancy mismatch, expected %0d actual %0d",
                 $time, want.occupancy, got.occupancy);
        faults++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [NONCE_W-1:0] s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;

  nonce_history hist;
  int unsigned  burst_left  = 0;
  int unsigned  cycle_count = 0;
  int unsigned  offered     = 0;

  duplicate_filter_fifo_evict i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: back-pressure pattern switching between modes now and then
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode   = RX_STEADY;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  logic        rx_ready;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(500, 3000);
    end else begin
      mode_left--;
    end
    rx_ready = 1'b1;
    if (hold_left != 0) begin
      hold_left--;
      rx_ready = 1'b0;
    end else begin
      case (rx_mode)
        RX_CHOPPY: begin
          if ($urandom_range(0, 2) == 0) begin
            hold_left = $urandom_range(0, 5);
            rx_ready  = 1'b0;
          end
        end
        RX_ALTERNATE: begin
          rx_ready = ~m_axis_tready;
        end
        RX_LONG: begin
          // stall long enough to hold the block in its commit step
          if ($urandom_range(0, 149) == 0) begin
            hold_left = $urandom_range(50, 300);
            rx_ready  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    m_axis_tready <= rx_ready;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) hist.check_verdict(m_axis_tdata);
  end

  // --------------------------------------------------------------------------
  // Sender: one transaction, then maybe a gap at the end of a burst
  // --------------------------------------------------------------------------
  task automatic offer_nonce(input nonce_t n, input bit last);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= n;
    do @(posedge clk_i); while (!s_axis_tready);
    hist.note_nonce(n);
    offered++;
    if (last) begin
      s_axis_tvalid <= 1'b0;
    end else if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      case ($urandom_range(0, 19))
        0:             gap = $urandom_range(20, 280);
        1, 2, 3, 4, 5: gap = 0;
        default:       gap = $urandom_range(1, 8);
      endcase
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= $urandom();
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // random nonce: fresh, a held entry, the oldest, a dropped one or a near miss
  function automatic nonce_t pick_nonce();
    int unsigned roll;
    nonce_t      n;
    roll = $urandom_range(0, 99);
    if (hist.held == 0 || roll < 50) begin
      n = $urandom();
    end else if (roll < 60) begin
      // repeating the oldest must not save it from the next eviction
      n = hist.ring[hist.head];
    end else if (roll < 82) begin
      n = hist.ring[(hist.head + $urandom_range(0, hist.held - 1)) % CAPACITY_ENTRIES];
    end else if (roll < 92 && hist.dropped_q.size() != 0) begin
      n = hist.dropped_q[$urandom_range(0, hist.dropped_q.size() - 1)];
    end else begin
      n = hist.ring[(hist.head + $urandom_range(0, hist.held - 1)) % CAPACITY_ENTRIES];
      n[$urandom_range(0, NONCE_W - 1)] ^= 1'b1;
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    nonce_t      directed_q[$];
    int unsigned i;
    hist = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, immediate repeats, single-bit near misses
    directed_q = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001,
                   32'h0000_0002, 32'h8000_0001, 32'h5555_5554, 32'h0000_0000,
                   32'hFFFF_FFFF, 32'h1234_5678, 32'h1234_5678};
    foreach (directed_q[k]) offer_nonce(directed_q[k], 1'b0);

    for (i = 0; i < RANDOM_ITEMS; i++) offer_nonce(pick_nonce(), i == RANDOM_ITEMS - 1);

    while (hist.verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d nonces: %0d new, %0d repeats, %0d evictions",
             offered, hist.fresh_cnt, hist.repeat_cnt, hist.drop_cnt);
    $display("%0d verdicts checked, final occupancy %0d, %0d faults",
             hist.checked_cnt, hist.held, hist.faults);
    if (hist.faults == 0 && hist.verdict_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
